>>> rtl/core/cau_pkg.sv
// Shared types and codes for the complex arithmetic unit.
// No dependencies; imported by the top module and the multiplier.
package cau_pkg;

	localparam int OP_BITS  = 3;
	localparam int EXP_BITS = 4;

	localparam logic [OP_BITS-1:0] OP_SUB = 3'd0;
	localparam logic [OP_BITS-1:0] OP_MUL = 3'd1;
	localparam logic [OP_BITS-1:0] OP_DIV = 3'd2;
	localparam logic [OP_BITS-1:0] OP_POW = 3'd3;
	localparam logic [OP_BITS-1:0] OP_MAG = 3'd4;

	// product selector: 0 xr*yr, 1 xi*yi, 2 xr*yi, 3 xi*yr
	typedef struct packed {
		logic       vld;
		logic [1:0] idx;
	} mul_tag_t;

endpackage

>>> rtl/core/complex_arithmetic_unit.sv
// Complex arithmetic unit: subtract, multiply, divide, power, magnitude in signed fixed point.
// Timing from input transaction to result hand-off depends on the operation, the exponent and the
// word and fraction widths (W word bits, F fraction bits): it is set by the shared multiplier and
// the one-bit-per-cycle divider and square-root units. One transaction at a time; in_ready is low
// from acceptance until the result is taken.
// Reset clears the sequencer and flags; no clearing pass. Depends on cau_pkg and submodules.
module complex_arithmetic_unit import cau_pkg::*; #(
	parameter int WORD_BITS    = 32,
	parameter int FRAC_BITS    = 24,
	parameter int MAX_EXPONENT = 15
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [OP_BITS-1:0]          opcode,
	input  logic signed [WORD_BITS-1:0] a_real,
	input  logic signed [WORD_BITS-1:0] a_imag,
	input  logic signed [WORD_BITS-1:0] b_real,
	input  logic signed [WORD_BITS-1:0] b_imag,
	input  logic [EXP_BITS-1:0]         exponent,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [WORD_BITS-1:0] res_real,
	output logic signed [WORD_BITS-1:0] res_imag,
	output logic                        div_by_zero,
	output logic                        overflow
);

	localparam int W  = WORD_BITS;
	localparam int AW = 2 * W + 1;
	localparam int NW = 2 * W + FRAC_BITS;

	localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] ONE  = W'(1) << FRAC_BITS;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL  = 3'd1;
	localparam logic [2:0] S_POST = 3'd2;
	localparam logic [2:0] S_DIVR = 3'd3;
	localparam logic [2:0] S_DIVI = 3'd4;
	localparam logic [2:0] S_SQRT = 3'd5;
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]            state_q;
	logic [OP_BITS-1:0]    op_q;
	logic                  phase_q;
	logic                  two_q;
	logic [2:0]            iss_q;
	logic [EXP_BITS-1:0]   cnt_q;
	logic signed [W-1:0]   ar_q, ai_q, br_q, bi_q;
	logic signed [W-1:0]   xr_q, xi_q, yr_q, yi_q;
	logic signed [AW-1:0]  acc_re_q, acc_im_q;
	logic signed [AW-1:0]  num_im_q;
	logic [2*W-1:0]        den_q;
	logic                  neg_q;
	logic signed [W-1:0]   res_re_q, res_im_q;
	logic                  dz_q, ov_q;

	logic signed [W-1:0]   mul_a, mul_b;
	mul_tag_t              tag_in, tag_out;
	logic signed [2*W-1:0] prod;
	logic signed [AW-1:0]  prod_x;
	logic [1:0]            last_idx;

	logic                  div_start, div_done;
	logic [NW-1:0]         div_num, div_quot;
	logic                  sq_start, sq_done;
	logic [W-1:0]          sq_root;

	logic [W:0]            sat_re, sat_im, qsat;
	logic [W:0]            sub_re, sub_im;
	logic signed [W:0]     d_re, d_im;
	logic [EXP_BITS-1:0]   n_clamp;
	logic [AW-1:0]         div_src;
	logic                  div_neg;
	logic [AW-1:0]         div_mag;

	function automatic logic [W:0] sat_acc(input logic signed [AW-1:0] v);
		logic signed [AW-1:0] sh;
		logic [AW-W:0]        hi;
		sh = v >>> FRAC_BITS;
		hi = sh[AW-1:W-1];
		if ((&hi) || !(|hi)) begin
			return {1'b0, sh[W-1:0]};
		end
		return {1'b1, sh[AW-1] ? WMIN : WMAX};
	endfunction

	function automatic logic [W:0] sat_diff(input logic signed [W:0] d);
		if (d[W] == d[W-1]) begin
			return {1'b0, d[W-1:0]};
		end
		return {1'b1, d[W] ? WMIN : WMAX};
	endfunction

	// quotient magnitude to signed word with saturation
	function automatic logic [W:0] sat_quot(input logic [NW-1:0] q, input logic neg);
		logic [NW-1:0] lim;
		lim = NW'(WMAX);
		if (neg) begin
			lim = lim + 1'b1;
		end
		if (q > lim) begin
			return {1'b1, neg ? WMIN : WMAX};
		end
		return {1'b0, neg ? (~q[W-1:0] + 1'b1) : q[W-1:0]};
	endfunction

	// operand selection for the shared multiplier
	always_comb begin
		case (iss_q[1:0])
			2'd0:    begin mul_a = xr_q; mul_b = yr_q; end
			2'd1:    begin mul_a = xi_q; mul_b = yi_q; end
			2'd2:    begin mul_a = xr_q; mul_b = yi_q; end
			default: begin mul_a = xi_q; mul_b = yr_q; end
		endcase
	end

	assign last_idx = two_q ? 2'd1 : 2'd3;
	assign tag_in   = '{vld: (state_q == S_MUL) && (iss_q <= {1'b0, last_idx}),
		idx: iss_q[1:0]};

	cau_mul #(.W(W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.op_a   (mul_a),
		.op_b   (mul_b),
		.tag_in (tag_in),
		.prod   (prod),
		.tag_out(tag_out)
	);

	assign prod_x = AW'(prod);

	assign sat_re = sat_acc(acc_re_q);
	assign sat_im = sat_acc(acc_im_q);
	assign d_re   = (W+1)'(a_real) - (W+1)'(b_real);
	assign d_im   = (W+1)'(a_imag) - (W+1)'(b_imag);
	assign sub_re = sat_diff(d_re);
	assign sub_im = sat_diff(d_im);
	assign qsat   = sat_quot(div_quot, neg_q);

	assign n_clamp = (int'(exponent) > MAX_EXPONENT) ? EXP_BITS'(MAX_EXPONENT) : exponent;

	// divider feed: real numerator from the post step, imaginary one afterwards
	assign div_start = ((state_q == S_POST) && (op_q == OP_DIV) && phase_q)
		|| ((state_q == S_DIVR) && div_done);
	assign div_src = (state_q == S_POST) ? acc_re_q : num_im_q;
	assign div_neg = div_src[AW-1];
	assign div_mag = div_neg ? (~div_src + 1'b1) : div_src;
	assign div_num = {div_mag[2*W-1:0], {FRAC_BITS{1'b0}}};

	cau_div #(.NW(NW), .DW(2 * W)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_num),
		.divisor (den_q),
		.done    (div_done),
		.quot    (div_quot)
	);

	assign sq_start = (state_q == S_POST) && (op_q == OP_MAG);

	cau_sqrt #(.W(W)) u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sq_start),
		.value (acc_re_q[2*W-1:0]),
		.done  (sq_done),
		.root  (sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iss_q   <= '0;
			phase_q <= 1'b0;
			dz_q    <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						iss_q   <= '0;
						phase_q <= 1'b0;
						dz_q    <= 1'b0;
						ov_q    <= 1'b0;
						if (opcode == OP_SUB) begin
							ov_q    <= sub_re[W] | sub_im[W];
							state_q <= S_OUT;
						end else if (opcode == OP_POW && n_clamp == '0) begin
							state_q <= S_OUT;
						end else if (opcode inside {OP_MUL, OP_DIV, OP_POW, OP_MAG}) begin
							state_q <= S_MUL;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_MUL: begin
					if (tag_in.vld) begin
						iss_q <= iss_q + 1'b1;
					end
					if (tag_out.vld && tag_out.idx == last_idx) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					iss_q <= '0;
					case (op_q)
						OP_MUL: begin
							ov_q    <= ov_q | sat_re[W] | sat_im[W];
							state_q <= S_OUT;
						end
						OP_POW: begin
							ov_q    <= ov_q | sat_re[W] | sat_im[W];
							state_q <= (cnt_q == EXP_BITS'(1)) ? S_OUT : S_MUL;
						end
						OP_MAG: begin
							state_q <= S_SQRT;
						end
						default: begin
							if (phase_q) begin
								state_q <= S_DIVR;
							end else if (acc_re_q == '0) begin
								dz_q    <= 1'b1;
								state_q <= S_OUT;
							end else begin
								phase_q <= 1'b1;
								state_q <= S_MUL;
							end
						end
					endcase
				end
				S_DIVR: begin
					if (div_done) begin
						ov_q    <= ov_q | qsat[W];
						state_q <= S_DIVI;
					end
				end
				S_DIVI: begin
					if (div_done) begin
						ov_q    <= ov_q | qsat[W];
						state_q <= S_OUT;
					end
				end
				S_SQRT: begin
					if (sq_done) begin
						ov_q    <= sq_root[W-1];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_q     <= opcode;
					ar_q     <= a_real;
					ai_q     <= a_imag;
					br_q     <= b_real;
					bi_q     <= b_imag;
					cnt_q    <= n_clamp;
					res_re_q <= '0;
					res_im_q <= '0;
					two_q    <= 1'b0;
					xr_q     <= a_real;
					xi_q     <= a_imag;
					yr_q     <= b_real;
					yi_q     <= b_imag;
					case (opcode)
						OP_SUB: begin
							res_re_q <= sub_re[W-1:0];
							res_im_q <= sub_im[W-1:0];
						end
						OP_DIV: begin
							// denominator pass first
							two_q <= 1'b1;
							xr_q  <= b_real;
							xi_q  <= b_imag;
						end
						OP_POW: begin
							res_re_q <= ONE;
							xr_q     <= ONE;
							xi_q     <= '0;
							yr_q     <= a_real;
							yi_q     <= a_imag;
						end
						OP_MAG: begin
							two_q <= 1'b1;
							yr_q  <= a_real;
							yi_q  <= a_imag;
						end
						default: begin
						end
					endcase
				end
			end
			S_MUL: begin
				if (tag_out.vld) begin
					case (tag_out.idx)
						2'd0: acc_re_q <= prod_x;
						2'd1: begin
							if (op_q == OP_MUL || op_q == OP_POW) begin
								acc_re_q <= acc_re_q - prod_x;
							end else begin
								acc_re_q <= acc_re_q + prod_x;
							end
						end
						2'd2: acc_im_q <= (op_q == OP_DIV) ? -prod_x : prod_x;
						default: acc_im_q <= acc_im_q + prod_x;
					endcase
				end
			end
			S_POST: begin
				case (op_q)
					OP_MUL: begin
						res_re_q <= sat_re[W-1:0];
						res_im_q <= sat_im[W-1:0];
					end
					OP_POW: begin
						res_re_q <= sat_re[W-1:0];
						res_im_q <= sat_im[W-1:0];
						xr_q     <= sat_re[W-1:0];
						xi_q     <= sat_im[W-1:0];
						cnt_q    <= cnt_q - 1'b1;
					end
					OP_MAG: begin
					end
					default: begin
						if (phase_q) begin
							num_im_q <= acc_im_q;
							neg_q    <= div_neg;
						end else begin
							den_q <= acc_re_q[2*W-1:0];
							two_q <= 1'b0;
							xr_q  <= ar_q;
							xi_q  <= ai_q;
							yr_q  <= br_q;
							yi_q  <= bi_q;
						end
					end
				endcase
			end
			S_DIVR: begin
				if (div_done) begin
					res_re_q <= qsat[W-1:0];
					neg_q    <= div_neg;
				end
			end
			S_DIVI: begin
				if (div_done) begin
					res_im_q <= qsat[W-1:0];
				end
			end
			S_SQRT: begin
				if (sq_done) begin
					res_re_q <= sq_root[W-1] ? WMAX : sq_root;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = (state_q == S_OUT);
	assign res_real    = res_re_q;
	assign res_imag    = res_im_q;
	assign div_by_zero = dz_q;
	assign overflow    = ov_q;

	// a zero divisor gives a zero result and never saturates
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_by_zero |-> res_real == '0 && res_imag == '0 && !overflow)
		else $error("zero-divisor result not cleared");

	// only one transaction in flight
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result is pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after acceptance");

	// the flag belongs to the divide opcode alone
	a_dz_op: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_by_zero |-> op_q == OP_DIV)
		else $error("divide-by-zero flag on another opcode");

endmodule

>>> rtl/core/cau_mul.sv
// Shared signed multiplier with registered product and tag.
// Depends on cau_pkg for the tag type.
module cau_mul import cau_pkg::*; #(
	parameter int W = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic signed [W-1:0]   op_a,
	input  logic signed [W-1:0]   op_b,
	input  mul_tag_t              tag_in,
	output logic signed [2*W-1:0] prod,
	output mul_tag_t              tag_out
);

	logic signed [2*W-1:0] prod_s1;
	mul_tag_t              tag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	assign prod    = prod_s1;
	assign tag_out = tag_s1;

endmodule

>>> rtl/core/cau_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; does not use cau_pkg.
module cau_div #(
	parameter int NW = 80,
	parameter int DW = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quot
);

	localparam int CW = $clog2(NW + 1);

	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   sh;
	logic [DW+1:0] diff;
	logic          ge;

	assign sh   = {rem_q, quo_q[NW-1]};
	assign diff = {1'b0, sh} - {2'b00, den_q};
	assign ge   = !diff[DW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DW-1:0] : sh[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

>>> rtl/core/cau_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Standalone; result is the floor of the root of a 2W-bit value.
module cau_sqrt #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [2*W-1:0] value,
	output logic           done,
	output logic [W-1:0]   root
);

	localparam int CW = $clog2(W + 1);

	logic [W+1:0]   rem_q;
	logic [W-1:0]   root_q;
	logic [2*W-1:0] val_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [W+3:0]   sh;
	logic [W+3:0]   trial;
	logic [W+4:0]   diff;
	logic           ge;

	assign sh    = {rem_q, val_q[2*W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign diff  = {1'b0, sh} - {1'b0, trial};
	assign ge    = !diff[W+4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			root_q <= '0;
			val_q  <= value;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[W+1:0] : sh[W+1:0];
			root_q <= {root_q[W-2:0], ge};
			val_q  <= {val_q[2*W-3:0], 2'b00};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
